[rtl/core/eulrot_pkg.sv]
// Shared types, constants and arithmetic helpers for the Euler X-Y-Z to rotation matrix block.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package eulrot_pkg;

  // Angle scaling, output format and CORDIC length
  localparam int ANGLE_WIDTH    = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int CORDIC_STAGES  = 16;

  // Field widths of the channels
  localparam int ANG_W = 16;
  localparam int OUT_W = 16;

  // Internal Q30 datapath widths
  localparam int WORK_FRAC = 30;
  localparam int PH_W      = 32;
  localparam int XY_W      = 32;
  localparam int Z_W       = 33;
  localparam int P_W       = 33;
  localparam int S_W       = 34;
  localparam int RND_SH    = WORK_FRAC - COEF_FRAC_BITS;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  z_t;
  typedef logic signed [P_W-1:0]  prod_t;
  typedef logic signed [S_W-1:0]  sum_t;

  // CORDIC gain compensation, 0.6072529350 in Q30
  localparam xy_t GAIN_Q30 = 32'sd652032874;

  // atan(2^-i) in units of 2^32 per turn
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  localparam logic signed [2*P_W-1:0] RND_MUL = (2*P_W)'(1) << (WORK_FRAC - 1);
  localparam sum_t RND_ADD = sum_t'((64'(1) << RND_SH) >> 1);
  localparam sum_t ONE_Q   = sum_t'(64'(1) << COEF_FRAC_BITS);

  typedef struct packed {
    logic signed [ANG_W-1:0] first_angle;
    logic signed [ANG_W-1:0] second_angle;
    logic signed [ANG_W-1:0] third_angle;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] rot_00;
    logic signed [OUT_W-1:0] rot_01;
    logic signed [OUT_W-1:0] rot_02;
    logic signed [OUT_W-1:0] rot_10;
    logic signed [OUT_W-1:0] rot_11;
    logic signed [OUT_W-1:0] rot_12;
    logic signed [OUT_W-1:0] rot_20;
    logic signed [OUT_W-1:0] rot_21;
    logic signed [OUT_W-1:0] rot_22;
  } rot_t;

  // Q30 by Q30 product, rounded half up back to Q30
  function automatic prod_t mulq(input prod_t a, input prod_t b);
    logic signed [2*P_W-1:0] p;
    p = a * b;
    p = p + RND_MUL;
    return p[WORK_FRAC +: P_W];
  endfunction

  // Q30 to output format: round half up, saturate to +-1.0, keep the field bits
  function automatic logic [OUT_W-1:0] to_out(input sum_t v);
    sum_t r;
    r = (v + RND_ADD) >>> RND_SH;
    if (r > ONE_Q) r = ONE_Q;
    if (r < -ONE_Q) r = -ONE_Q;
    return r[OUT_W-1:0];
  endfunction

endpackage

[rtl/core/eulrot_ang_if.sv]
// Input channel carrying the three Euler angles of one transaction.
// Depends on eulrot_pkg for the payload type.
`timescale 1ns / 1ps

interface eulrot_ang_if;
  import eulrot_pkg::*;

  logic    valid;
  logic    ready;
  angles_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/eulrot_rot_if.sv]
// Output channel carrying the nine rotation matrix elements of one transaction.
// Depends on eulrot_pkg for the payload type.
`timescale 1ns / 1ps

interface eulrot_rot_if;
  import eulrot_pkg::*;

  logic valid;
  logic ready;
  rot_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/euler_xyz_to_rotation_matrix.sv]
// Euler X-Y-Z (1-2-3) angles to 3x3 rotation matrix, fully pipelined.
// Depends on eulrot_pkg, eulrot_ang_if and eulrot_rot_if.
//
//   channel | direction | payload                                    | handshake
//   ang_i   | in        | first_angle, second_angle, third_angle     | valid/ready
//   rot_o   | out       | rot_00 .. rot_22, signed Q1.14             | valid/ready
//
// One transaction enters per cycle while ang_i.ready is high; the result passes through the
// unrolled CORDIC plus angle prep, sign fix, two multiplier stages, a sum stage and the
// output rounding stage.
// rst_ni clears all valid bits asynchronously; payload registers are not reset.
// An output stall fills a one-entry skid buffer; only while it is full does the
// whole pipeline hold and ang_i.ready drop.
`timescale 1ns / 1ps

module euler_xyz_to_rotation_matrix (
  input  logic        clk_i,
  input  logic        rst_ni,
  eulrot_ang_if.sink   ang_i,
  eulrot_rot_if.source rot_o
);
  import eulrot_pkg::*;

  localparam int NSTG = CORDIC_STAGES + 6;

  logic            en;
  logic [NSTG-1:0] vld_q;
  logic            skid_vld_q;
  rot_t            skid_q;

  // CORDIC state per stage and angle
  xy_t      cx_q   [CORDIC_STAGES+1][3];
  xy_t      cy_q   [CORDIC_STAGES+1][3];
  z_t       cz_q   [CORDIC_STAGES+1][3];
  logic [2:0] flip_q [CORDIC_STAGES+1];

  xy_t   sin_q [3];
  xy_t   cos_q [3];

  prod_t m_c2c3_q, m_c1s3_q, m_c3s1_q, m_s1s3_q, m_c1c3_q;
  prod_t m_c2s3_q, m_s1s2_q, m_c1s2_q, m_c2s1_q, m_c1c2_q;
  prod_t s2_p1_q, s3_p1_q;

  prod_t t_c3s1s2_q, t_c1c3s2_q, t_s1s2s3_q, t_c1s2s3_q;
  prod_t n_c2c3_q, n_c1s3_q, n_s1s3_q, n_c2s3_q, n_c1c3_q;
  prod_t n_c3s1_q, n_s2_q, n_c2s1_q, n_c1c2_q;

  sum_t  sum_q [9];
  rot_t  out_q;

  angles_t ang_in;
  logic [ANG_W-1:0] ang_raw [3];

  // Advance the whole pipeline unless the skid buffer holds a result
  assign en          = !skid_vld_q;
  assign ang_i.ready = en;
  assign ang_in      = ang_i.data;
  assign ang_raw[0]  = ang_in.first_angle;
  assign ang_raw[1]  = ang_in.second_angle;
  assign ang_raw[2]  = ang_in.third_angle;

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], ang_i.valid};
    end
  end

  // Map angles to 32-bit phase, fold the back half-plane by pi
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [PH_W-1:0] ph;
        logic            fl;
        ph = PH_W'(ang_raw[k]) << (PH_W - ANGLE_WIDTH);
        fl = (ph[PH_W-1:PH_W-2] == 2'b01) || (ph[PH_W-1:PH_W-2] == 2'b10);
        ph[PH_W-1] = ph[PH_W-1] ^ fl;
        cx_q[0][k]   <= GAIN_Q30;
        cy_q[0][k]   <= '0;
        cz_q[0][k]   <= z_t'(signed'(ph));
        flip_q[0][k] <= fl;
      end
    end
  end

  // Unrolled rotation-mode CORDIC, one micro-rotation per stage
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (!cz_q[g][k][Z_W-1]) begin
            cx_q[g+1][k] <= cx_q[g][k] - (cy_q[g][k] >>> g);
            cy_q[g+1][k] <= cy_q[g][k] + (cx_q[g][k] >>> g);
            cz_q[g+1][k] <= cz_q[g][k] - z_t'(ATAN_TURN[g]);
          end else begin
            cx_q[g+1][k] <= cx_q[g][k] + (cy_q[g][k] >>> g);
            cy_q[g+1][k] <= cy_q[g][k] - (cx_q[g][k] >>> g);
            cz_q[g+1][k] <= cz_q[g][k] + z_t'(ATAN_TURN[g]);
          end
        end
        flip_q[g+1] <= flip_q[g];
      end
    end
  end

  // Undo the half-turn fold
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sin_q[k] <= flip_q[CORDIC_STAGES][k] ? -cy_q[CORDIC_STAGES][k] : cy_q[CORDIC_STAGES][k];
        cos_q[k] <= flip_q[CORDIC_STAGES][k] ? -cx_q[CORDIC_STAGES][k] : cx_q[CORDIC_STAGES][k];
      end
    end
  end

  // Pair products
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_c2c3_q <= mulq(prod_t'(cos_q[1]), prod_t'(cos_q[2]));
      m_c1s3_q <= mulq(prod_t'(cos_q[0]), prod_t'(sin_q[2]));
      m_c3s1_q <= mulq(prod_t'(cos_q[2]), prod_t'(sin_q[0]));
      m_s1s3_q <= mulq(prod_t'(sin_q[0]), prod_t'(sin_q[2]));
      m_c1c3_q <= mulq(prod_t'(cos_q[0]), prod_t'(cos_q[2]));
      m_c2s3_q <= mulq(prod_t'(cos_q[1]), prod_t'(sin_q[2]));
      m_s1s2_q <= mulq(prod_t'(sin_q[0]), prod_t'(sin_q[1]));
      m_c1s2_q <= mulq(prod_t'(cos_q[0]), prod_t'(sin_q[1]));
      m_c2s1_q <= mulq(prod_t'(cos_q[1]), prod_t'(sin_q[0]));
      m_c1c2_q <= mulq(prod_t'(cos_q[0]), prod_t'(cos_q[1]));
      s2_p1_q  <= prod_t'(sin_q[1]);
      s3_p1_q  <= prod_t'(sin_q[2]);
    end
  end

  // Triple products, carry the pair products along
  always_ff @(posedge clk_i) begin
    if (en) begin
      t_c3s1s2_q <= mulq(m_c3s1_q, s2_p1_q);
      t_c1c3s2_q <= mulq(m_c1c3_q, s2_p1_q);
      t_s1s2s3_q <= mulq(m_s1s2_q, s3_p1_q);
      t_c1s2s3_q <= mulq(m_c1s2_q, s3_p1_q);
      n_c2c3_q   <= m_c2c3_q;
      n_c1s3_q   <= m_c1s3_q;
      n_s1s3_q   <= m_s1s3_q;
      n_c2s3_q   <= m_c2s3_q;
      n_c1c3_q   <= m_c1c3_q;
      n_c3s1_q   <= m_c3s1_q;
      n_s2_q     <= s2_p1_q;
      n_c2s1_q   <= m_c2s1_q;
      n_c1c2_q   <= m_c1c2_q;
    end
  end

  // Combine into matrix elements, exact in Q30
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q[0] <= sum_t'(n_c2c3_q);
      sum_q[1] <= sum_t'(n_c1s3_q) + sum_t'(t_c3s1s2_q);
      sum_q[2] <= sum_t'(n_s1s3_q) - sum_t'(t_c1c3s2_q);
      sum_q[3] <= -sum_t'(n_c2s3_q);
      sum_q[4] <= sum_t'(n_c1c3_q) - sum_t'(t_s1s2s3_q);
      sum_q[5] <= sum_t'(n_c3s1_q) + sum_t'(t_c1s2s3_q);
      sum_q[6] <= sum_t'(n_s2_q);
      sum_q[7] <= -sum_t'(n_c2s1_q);
      sum_q[8] <= sum_t'(n_c1c2_q);
    end
  end

  // Round and saturate to Q1.14
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.rot_00 <= to_out(sum_q[0]);
      out_q.rot_01 <= to_out(sum_q[1]);
      out_q.rot_02 <= to_out(sum_q[2]);
      out_q.rot_10 <= to_out(sum_q[3]);
      out_q.rot_11 <= to_out(sum_q[4]);
      out_q.rot_12 <= to_out(sum_q[5]);
      out_q.rot_20 <= to_out(sum_q[6]);
      out_q.rot_21 <= to_out(sum_q[7]);
      out_q.rot_22 <= to_out(sum_q[8]);
    end
  end

  // Catch the last stage when the sink stalls; drain when it takes the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en && vld_q[NSTG-1] && !rot_o.ready) begin
      skid_vld_q <= 1'b1;
    end else if (skid_vld_q && rot_o.ready) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NSTG-1] && !rot_o.ready) begin
      skid_q <= out_q;
    end
  end

  // Older result in the skid buffer goes out first
  assign rot_o.valid = skid_vld_q || vld_q[NSTG-1];
  assign rot_o.data  = skid_vld_q ? skid_q : out_q;

  // The skid buffer fills only from a stalled, valid output
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(rot_o.valid && !rot_o.ready))
    else $error("skid buffer loaded without an output stall");

  // An accepted transaction occupies the first stage next cycle
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ang_i.valid && ang_i.ready) |=> vld_q[0])
    else $error("accepted transaction missing from first stage");

  // A full skid buffer freezes every pipeline stage
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(vld_q))
    else $error("pipeline moved while the skid buffer was full");

endmodule
